/* hw/rtl/text_console_writer_defines.svh */
// Assertion helpers for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTH
// Check that an implication holds at every rising edge outside reset.
`define TCW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define TCW_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rstn, prop, msg)
`define TCW_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* hw/rtl/tcw_pkg.sv */
package tcw_pkg;

  // Field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  // Screen geometry
  localparam int ROWS           = 25;
  localparam int COLS           = 80;
  localparam int FIRST_TEXT_ROW = 2;
  localparam int NCELLS         = ROWS * COLS;
  localparam int ADDR_W         = $clog2(NCELLS);
  localparam int SCROLL_BASE    = FIRST_TEXT_ROW * COLS;
  localparam int LAST_ROW_BASE  = (ROWS - 1) * COLS;

  localparam logic [CELL_W-1:0] BLANK_RESET  = 16'h0120;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic clear;    // write one reset cell of the clearing pass
    logic accept;   // capture an input beat
    logic decode;   // apply a put item, or issue a cell read
    logic capture;  // take the read data
    logic scroll;   // move one cell of the scroll sweep
    logic emit;     // load the output register
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic is_read;
    logic do_scroll;
    logic out_free;
  } tcw_sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(int'(row) * COLS + int'(col));
  endfunction

endpackage

/* hw/rtl/tcw_ifs.sv */
interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::CHAR_W-1:0]   attr;
  logic [tcw_pkg::ROW_W-1:0]    read_row;
  logic [tcw_pkg::COL_W-1:0]    read_col;

  modport source (output valid, mode, char_code, attr, read_row, read_col, input ready);
  modport sink   (input valid, mode, char_code, attr, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tcw_pkg::COL_W-1:0]    cursor_col;
  logic [tcw_pkg::CELL_W-1:0]   cell_value;
  logic                         scrolled;

  modport source (output valid, cursor_row, cursor_col, cell_value, scrolled, input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_value, scrolled, output ready);
endinterface

/* hw/rtl/tcw_ctrl.sv */
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_RDWAIT = 6'b001000,
    S_SCROLL = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.is_read) begin
          state_d = S_RDWAIT;
        end else if (sts_i.do_scroll) begin
          state_d = S_SCROLL;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_RDWAIT: begin
        cmd_o.capture = 1'b1;
        state_d       = S_RESULT;
      end
      S_SCROLL: begin
        cmd_o.scroll = 1'b1;
        if (sts_i.sweep_last) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

/* hw/rtl/tcw_datapath.sv */
module tcw_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::CELL_W-1:0] cfg_wdata_i,
  input  tcw_pkg::tcw_cmd_t          cmd_i,
  output tcw_pkg::tcw_sts_t          sts_o,
  input  logic                       mode_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::CHAR_W-1:0] attr_i,
  input  logic [tcw_pkg::ROW_W-1:0]  read_row_i,
  input  logic [tcw_pkg::COL_W-1:0]  read_col_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col_o,
  output logic [tcw_pkg::CELL_W-1:0] cell_value_o,
  output logic                       scrolled_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int RW = tcw_pkg::ROW_W;
  localparam int CW = tcw_pkg::COL_W;

  // Screen store
  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::NCELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;

  // Held item
  logic                       mode_q;
  logic [tcw_pkg::CHAR_W-1:0] char_q, attr_q;
  logic [RW-1:0]              rrow_q;
  logic [CW-1:0]              rcol_q;

  logic [tcw_pkg::CELL_W-1:0] blank_q;
  logic [RW-1:0]              row_q, row_d;
  logic [CW-1:0]              col_q, col_d;
  logic [AW-1:0]              sweep_q;
  logic                       cpy_pend_q;
  logic [AW-1:0]              cpy_addr_q;
  logic                       scrolled_q;
  logic [tcw_pkg::CELL_W-1:0] cell_q;

  logic                       out_valid_q;
  logic [RW-1:0]              out_row_q;
  logic [CW-1:0]              out_col_q;
  logic [tcw_pkg::CELL_W-1:0] out_cell_q;
  logic                       out_scr_q;

  // Decode of the held item
  logic          is_nl, is_bs, adv_row, past_end, rd_ok, dec_we;
  logic [RW:0]   row_inc;
  logic [CW:0]   col_inc;
  logic [AW-1:0] dec_addr;
  logic [tcw_pkg::CELL_W-1:0] dec_data;

  always_comb begin
    is_nl    = (char_q == tcw_pkg::CH_NEWLINE);
    is_bs    = (char_q == tcw_pkg::CH_BACKSPACE);
    row_inc  = {1'b0, row_q} + 1'b1;
    col_inc  = {1'b0, col_q} + 1'b1;
    past_end = (int'(row_inc) >= tcw_pkg::ROWS);
    rd_ok    = (int'(rrow_q) < tcw_pkg::ROWS) && (int'(rcol_q) < tcw_pkg::COLS);
    adv_row  = 1'b0;
    dec_we   = 1'b0;
    dec_addr = tcw_pkg::cell_addr(row_q, col_q);
    dec_data = {attr_q, char_q};
    row_d    = row_q;
    col_d    = col_q;
    if (is_nl) begin
      adv_row = 1'b1;
    end else if (is_bs) begin
      if (col_q != '0) begin
        dec_we   = 1'b1;
        col_d    = col_q - 1'b1;
        dec_addr = tcw_pkg::cell_addr(row_q, col_q - 1'b1);
        dec_data = {attr_q, tcw_pkg::CH_SPACE};
      end
    end else begin
      dec_we = 1'b1;
      col_d  = col_inc[CW-1:0];
      if (int'(col_inc) >= tcw_pkg::COLS) adv_row = 1'b1;
    end
    if (adv_row) begin
      col_d = '0;
      row_d = past_end ? RW'(tcw_pkg::ROWS - 1) : row_inc[RW-1:0];
    end
  end

  // Memory ports: the clearing pass, a put write and the scroll copy never overlap
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_q;
    mem_wdata = tcw_pkg::BLANK_RESET;
    if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.decode && (mode_q == tcw_pkg::MODE_PUT) && dec_we) begin
      mem_we    = 1'b1;
      mem_waddr = dec_addr;
      mem_wdata = dec_data;
    end else if (cpy_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = cpy_addr_q;
      mem_wdata = (cpy_addr_q >= AW'(tcw_pkg::LAST_ROW_BASE)) ? blank_q : rdata_q;
    end
    if (cmd_i.scroll) begin
      mem_raddr = sweep_q + AW'(tcw_pkg::COLS);
    end else begin
      mem_raddr = rd_ok ? tcw_pkg::cell_addr(rrow_q, rcol_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_i;
      char_q <= char_code_i;
      attr_q <= attr_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
    if (cmd_i.decode) begin
      cell_q     <= '0;
      scrolled_q <= (mode_q == tcw_pkg::MODE_PUT) && adv_row && past_end;
    end else if (cmd_i.capture) begin
      cell_q <= rd_ok ? rdata_q : '0;
    end
    if (cmd_i.scroll) cpy_addr_q <= sweep_q;
    if (cmd_i.emit) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_cell_q <= cell_q;
      out_scr_q  <= scrolled_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q     <= tcw_pkg::BLANK_RESET;
      row_q       <= RW'(tcw_pkg::FIRST_TEXT_ROW);
      col_q       <= '0;
      sweep_q     <= '0;
      cpy_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) blank_q <= cfg_wdata_i;
      if (cmd_i.decode && (mode_q == tcw_pkg::MODE_PUT)) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (cmd_i.decode) begin
        sweep_q <= AW'(tcw_pkg::SCROLL_BASE);
      end else if (cmd_i.clear || cmd_i.scroll) begin
        sweep_q <= sweep_q + 1'b1;
      end
      cpy_pend_q <= cmd_i.scroll;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.sweep_last = (sweep_q == AW'(tcw_pkg::NCELLS - 1));
    sts_o.is_read    = (mode_q == tcw_pkg::MODE_READ);
    sts_o.do_scroll  = adv_row && past_end;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cell_value_o = out_cell_q;
  assign scrolled_o   = out_scr_q;

endmodule

/* hw/rtl/text_console_writer.sv */
// Text console writer: a 25-row by 80-column screen of 16-bit cells
// ({attribute, character}) with a cursor that starts at row 2, column 0.
// A put beat writes a character and advances the cursor, a newline moves to
// column 0 of the next row, a backspace steps back and blanks one cell
// (nothing at column 0); running off the bottom row scrolls rows 3..24 up
// by one, fills the bottom row with blank_cell and leaves the cursor on
// row 24. A read beat returns one cell, or zero outside the screen. Every
// input beat gives exactly one result beat carrying the cursor after it.
// Timing: after reset the store is cleared to 0x0120 one cell a cycle, so
// no input beat is taken until the clearing pass ends (blank_cell writes are
// taken at any time). A put then passes through the decode and result states
// to the result register, a read also through a read-wait state, because the
// screen store has one read and one write port with registered read data. A
// put that scrolls also runs a sweep that streams 1840 cells through that same
// pair of ports, one cell a cycle. One beat is in work at a time; a new beat is
// accepted while the previous result still waits at the output.
module text_console_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::CELL_W-1:0] cfg_wdata_i,
  tcw_in_if.sink                     in_i,
  tcw_out_if.source                  out_o
);

  `include "text_console_writer_defines.svh"

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;

  // Sequencer: clearing pass, accept, decode, read wait, scroll sweep, result hand-off
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Screen store, cursor, blank_cell and the output register
  tcw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (in_i.mode),
    .char_code_i  (in_i.char_code),
    .attr_i       (in_i.attr),
    .read_row_i   (in_i.read_row),
    .read_col_i   (in_i.read_col),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .cursor_row_o (out_o.cursor_row),
    .cursor_col_o (out_o.cursor_col),
    .cell_value_o (out_o.cell_value),
    .scrolled_o   (out_o.scrolled)
  );

  // A result beat never overwrites one still waiting at the output
  `TCW_ASSERT(a_emit_free, clk_i, rst_ni, cmd.emit |-> sts.out_free, "result overwritten")

  // No input beat is taken while a scroll sweep is moving rows
  `TCW_ASSERT_NEVER(a_no_accept_scroll, clk_i, rst_ni, cmd.scroll && in_i.ready, "accept in scroll")

  // The cursor reported stays inside the text area
  `TCW_ASSERT(a_cursor_range, clk_i, rst_ni, out_o.valid |-> (int'(out_o.cursor_row) >= tcw_pkg::FIRST_TEXT_ROW && int'(out_o.cursor_row) < tcw_pkg::ROWS && int'(out_o.cursor_col) < tcw_pkg::COLS), "cursor out of range")

  // A scroll always leaves the cursor at the start of the bottom row
  `TCW_ASSERT(a_scroll_cursor, clk_i, rst_ni, (out_o.valid && out_o.scrolled) |-> (int'(out_o.cursor_row) == tcw_pkg::ROWS - 1 && out_o.cursor_col == '0), "bad cursor after scroll")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  // Longest stretch without any beat is the clearing pass or a scroll on top
  // of the long output hold-off; allow several times that.
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic                       mode;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::CHAR_W-1:0] attr;
    logic [tcw_pkg::ROW_W-1:0]  read_row;
    logic [tcw_pkg::COL_W-1:0]  read_col;
  } console_beat_t;

  typedef struct {
    logic [tcw_pkg::ROW_W-1:0]  cursor_row;
    logic [tcw_pkg::COL_W-1:0]  cursor_col;
    logic [tcw_pkg::CELL_W-1:0] cell_value;
    logic                       scrolled;
  } console_view_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [tcw_pkg::CELL_W-1:0] cfg_wdata;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();

  text_console_writer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the console: screen contents, cursor and the blank cell
  logic [tcw_pkg::CELL_W-1:0] screen_mirror [tcw_pkg::NCELLS];
  int                         cur_row;
  int                         cur_col;
  logic [tcw_pkg::CELL_W-1:0] blank_mirror;

  // Cursor/cell views still owed by the block, oldest first
  console_view_t     owed_views[$];

  int  fail_count    = 0;
  int  idle_cycles   = 0;
  int  hold_off_req  = 0;
  bit  in_idle_on    = 1'b1;
  bit  out_idle_on   = 1'b1;

  // ---------------------------------------------------------------------------
  // Console mirror
  // ---------------------------------------------------------------------------

  // Step to column 0 of the next row; scroll the text rows when running off
  // the bottom. Returns 1 when a scroll happened.
  function automatic logic advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= tcw_pkg::ROWS) begin
      // shift rows FIRST_TEXT_ROW+1..ROWS-1 up by one, header rows untouched
      for (int i = tcw_pkg::SCROLL_BASE; i < tcw_pkg::LAST_ROW_BASE; i++)
        screen_mirror[i] = screen_mirror[i + tcw_pkg::COLS];
      for (int i = tcw_pkg::LAST_ROW_BASE; i < tcw_pkg::NCELLS; i++)
        screen_mirror[i] = blank_mirror;
      cur_row = tcw_pkg::ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted beat to the mirror and return the view it should give
  function automatic console_view_t apply_to_console(console_beat_t beat);
    console_view_t view;
    view.cell_value = '0;
    view.scrolled   = 1'b0;
    if (beat.mode == tcw_pkg::MODE_READ) begin
      // reads off the screen give zero and change nothing
      if (beat.read_row < tcw_pkg::ROWS && beat.read_col < tcw_pkg::COLS)
        view.cell_value =
          screen_mirror[int'(beat.read_row) * tcw_pkg::COLS + int'(beat.read_col)];
    end else if (beat.char_code == tcw_pkg::CH_NEWLINE) begin
      view.scrolled = advance_row();
    end else if (beat.char_code == tcw_pkg::CH_BACKSPACE) begin
      // backspace at column 0 is a no-op
      if (cur_col > 0) begin
        cur_col--;
        screen_mirror[cur_row * tcw_pkg::COLS + cur_col] = {beat.attr, tcw_pkg::CH_SPACE};
      end
    end else begin
      screen_mirror[cur_row * tcw_pkg::COLS + cur_col] = {beat.attr, beat.char_code};
      cur_col++;
      if (cur_col >= tcw_pkg::COLS)
        view.scrolled = advance_row();
    end
    view.cursor_row = tcw_pkg::ROW_W'(cur_row);
    view.cursor_col = tcw_pkg::COL_W'(cur_col);
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------

  function automatic console_beat_t put_beat(int ch, int at);
    console_beat_t b;
    b.mode      = tcw_pkg::MODE_PUT;
    b.char_code = tcw_pkg::CHAR_W'(ch);
    b.attr      = tcw_pkg::CHAR_W'(at);
    b.read_row  = tcw_pkg::ROW_W'($urandom_range(0, 31));
    b.read_col  = tcw_pkg::COL_W'($urandom_range(0, 127));
    return b;
  endfunction

  function automatic console_beat_t read_beat(int row, int col);
    console_beat_t b;
    b.mode      = tcw_pkg::MODE_READ;
    b.char_code = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    b.attr      = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    b.read_row  = tcw_pkg::ROW_W'(row);
    b.read_col  = tcw_pkg::COL_W'(col);
    return b;
  endfunction

  // Mostly puts of arbitrary bytes with a sprinkling of newlines and
  // backspaces; reads lean towards the cursor's neighbourhood so that fresh
  // writes get read back, with the odd one off the screen.
  function automatic console_beat_t random_console_beat();
    console_beat_t b;
    int            pick;
    b = put_beat($urandom_range(0, 255), $urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      b.mode = tcw_pkg::MODE_READ;
      pick   = $urandom_range(0, 9);
      if (pick < 4) begin
        b.read_row = tcw_pkg::ROW_W'(cur_row - $urandom_range(0, 1));
        b.read_col = tcw_pkg::COL_W'($urandom_range(0, cur_col));
      end else if (pick < 9) begin
        b.read_row = tcw_pkg::ROW_W'($urandom_range(0, tcw_pkg::ROWS - 1));
        b.read_col = tcw_pkg::COL_W'($urandom_range(0, tcw_pkg::COLS - 1));
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 7)
        b.char_code = tcw_pkg::CH_NEWLINE;
      else if (pick < 15)
        b.char_code = tcw_pkg::CH_BACKSPACE;
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one beat after a random gap and hold it until it is taken; leave
  // valid high so that a back-to-back beat needs no second assignment.
  task automatic send_beat(input console_beat_t beat);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= beat.mode;
    in_if.char_code <= beat.char_code;
    in_if.attr      <= beat.attr;
    in_if.read_row  <= beat.read_row;
    in_if.read_col  <= beat.read_col;
    do @(posedge clk); while (!in_if.ready);
    owed_views.push_back(apply_to_console(beat));
  endtask

  // Drop valid and wait for a clock edge so that no stale beat can be taken
  task automatic quiet_input();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write blank_cell only once every owed view has come back: the block then
  // holds no beat and no scroll is under way.
  task automatic set_blank_cell(input logic [tcw_pkg::CELL_W-1:0] value);
    while (owed_views.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    blank_mirror  = value;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Draw a stall before every result; on a hold-off request drop ready for
  // the whole stretch, counted here.
  initial begin : result_receiver
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 5) : 0;
      if (hold_off_req > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_off_req) @(posedge clk);
        hold_off_req = 0;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk);
      while (!(out_if.valid && out_if.ready) && hold_off_req == 0);
    end
  end

  // Compare every result beat with the oldest owed view
  always @(posedge clk) begin : result_check
    console_view_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (owed_views.size() == 0) begin
        $error("result beat with nothing owed: row %0d col %0d cell %h",
               out_if.cursor_row, out_if.cursor_col, out_if.cell_value);
        fail_count++;
      end else begin
        want = owed_views.pop_front();
        if (out_if.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_if.cursor_row);
          fail_count++;
        end
        if (out_if.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, out_if.cursor_col);
          fail_count++;
        end
        if (out_if.cell_value !== want.cell_value) begin
          $error("cell_value: expected %h, got %h", want.cell_value, out_if.cell_value);
          fail_count++;
        end
        if (out_if.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want.scrolled, out_if.scrolled);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("text_console_writer: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Read the corners of the header rows and the bottom row straight after the
  // clearing pass, plus reads off the right and bottom edges.
  task automatic test_cleared_screen();
    send_beat(read_beat(0, 0));
    send_beat(read_beat(tcw_pkg::FIRST_TEXT_ROW - 1, tcw_pkg::COLS - 1));
    send_beat(read_beat(tcw_pkg::ROWS - 1, tcw_pkg::COLS - 1));
    send_beat(read_beat(tcw_pkg::ROWS, 0));
    send_beat(read_beat(31, 127));
    send_beat(read_beat(0, tcw_pkg::COLS));
    quiet_input();
  endtask

  // Extremes of character and attribute, backspace mid-row and at column 0,
  // newline, then read the touched cells back.
  task automatic test_put_ops();
    send_beat(put_beat(8'hFF, 8'hFF));
    send_beat(put_beat(8'h00, 8'h00));
    send_beat(put_beat(tcw_pkg::CH_BACKSPACE, 8'hA5));
    send_beat(read_beat(tcw_pkg::FIRST_TEXT_ROW, 0));
    send_beat(read_beat(tcw_pkg::FIRST_TEXT_ROW, 1));
    send_beat(read_beat(tcw_pkg::FIRST_TEXT_ROW, 2));
    send_beat(put_beat(tcw_pkg::CH_NEWLINE, 8'h5A));
    send_beat(put_beat(tcw_pkg::CH_BACKSPACE, 8'h5A));
    send_beat(read_beat(cur_row, 0));
    quiet_input();
  endtask

  // Walk down to the bottom row, mark a cell there and newline off the end;
  // the mark must move up a row and the bottom row take the blank cell.
  task automatic test_scroll();
    int mark_col;
    while (cur_row != tcw_pkg::ROWS - 1)
      send_beat(put_beat(tcw_pkg::CH_NEWLINE, $urandom_range(0, 255)));
    mark_col = cur_col;
    send_beat(put_beat("A", 8'h1E));
    send_beat(put_beat(tcw_pkg::CH_NEWLINE, 8'h00));
    send_beat(read_beat(tcw_pkg::ROWS - 2, mark_col));
    send_beat(read_beat(tcw_pkg::ROWS - 1, 0));
    send_beat(read_beat(tcw_pkg::ROWS - 1, tcw_pkg::COLS - 1));
    send_beat(read_beat(tcw_pkg::FIRST_TEXT_ROW - 1, mark_col));
    quiet_input();
  endtask

  // Hold the output off for a long stretch while beats keep coming, so that
  // the result register fills and the input stalls.
  task automatic test_back_pressure();
    in_idle_on   = 1'b0;
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (16) send_beat(random_console_beat());
    quiet_input();
    in_idle_on = 1'b1;
  endtask

  // Random text in blocks of 40 beats, each block with its own idling mix
  task automatic test_random_text(input int n_beats);
    for (int i = 0; i < n_beats; i++) begin
      if (i % 40 == 0) begin
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
      end
      send_beat(random_console_beat());
    end
    quiet_input();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.mode      = tcw_pkg::MODE_PUT;
    in_if.char_code = '0;
    in_if.attr      = '0;
    in_if.read_row  = '0;
    in_if.read_col  = '0;

    for (int i = 0; i < tcw_pkg::NCELLS; i++)
      screen_mirror[i] = tcw_pkg::BLANK_RESET;
    cur_row      = tcw_pkg::FIRST_TEXT_ROW;
    cur_col      = 0;
    blank_mirror = tcw_pkg::BLANK_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_blank_cell(tcw_pkg::CELL_W'($urandom_range(0, 65535)));
    test_cleared_screen();
    test_put_ops();
    test_random_text(300);
    set_blank_cell(16'hFFFF);
    test_scroll();
    test_back_pressure();
    set_blank_cell(16'h0000);
    test_random_text(300);
    set_blank_cell(tcw_pkg::BLANK_RESET);
    test_random_text(300);

    // drain, then keep watching for any stray result beat
    while (owed_views.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

endmodule
